>>> rtl/core/smpwm_pkg.sv
// ----------------------------------------------------------------------------
// smpwm_pkg
// Shared types and constants for the staggered multichannel PWM block.
// ----------------------------------------------------------------------------
`default_nettype none

package smpwm_pkg;

    // Field and register widths
    localparam int unsigned VALUE_W   = 32;
    localparam int unsigned PERIOD_W  = 32;
    localparam int unsigned STAGGER_W = 16;
    localparam int unsigned PIN_W     = 8;
    localparam int unsigned PIN_IDX_W = 3;
    localparam int unsigned CHAN_W    = 3;
    localparam int unsigned CFG_IDX_W = 4;

    // Reset values
    localparam logic [PERIOD_W-1:0]  RESET_PERIOD  = 32'h000C_3500;
    localparam logic [STAGGER_W-1:0] RESET_STAGGER = 16'd200;
    localparam logic [VALUE_W-1:0]   RESET_WIDTH   = 32'd200000;
    localparam logic [PIN_W-1:0]     ENABLE_ALL    = 8'hFF;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_PERIOD  = 4'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_STAGGER = 4'd1;

    // Item function codes
    typedef enum logic [1:0] {
        FUNC_TICK  = 2'd0,
        FUNC_WIDTH = 2'd1,
        FUNC_MASK  = 2'd2
    } t_func;

    typedef struct packed {
        t_func               func;
        logic [CHAN_W-1:0]   channel;
        logic [VALUE_W-1:0]  value;
    } t_in_item;

    typedef struct packed {
        logic [PIN_W-1:0] pins;
        logic             period_start;
    } t_out_item;

    // Controller states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DECODE,
        ST_LOAD,
        ST_CMP,
        ST_START,
        ST_PINS,
        ST_EMIT
    } t_state;

    // Controller to datapath commands
    typedef struct packed {
        logic capture;
        logic decode;
        logic load;
        logic cmp;
        logic start;
        logic pins;
        logic emit;
    } t_cmd;

    // Datapath to controller status
    typedef struct packed {
        logic is_tick;
        logic latch;
        logic j_last;
        logic i_last;
        logic out_free;
    } t_sts;

endpackage

`default_nettype wire

>>> rtl/core/smpwm_ctrl.sv
// ----------------------------------------------------------------------------
// smpwm_ctrl
// Sequencer: decodes an item, steps the ranking exchange, evaluates pins
// and hands the result to the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module smpwm_ctrl (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_in_valid,
    input  smpwm_pkg::t_sts      i_sts,
    output logic                 o_busy,
    output smpwm_pkg::t_cmd      o_cmd
);

    smpwm_pkg::t_state r_state;
    smpwm_pkg::t_state n_state;

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= smpwm_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state and commands
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            smpwm_pkg::ST_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.capture = 1'b1;
                    n_state       = smpwm_pkg::ST_DECODE;
                end
            end
            smpwm_pkg::ST_DECODE: begin
                o_cmd.decode = 1'b1;
                if (!i_sts.is_tick) begin
                    n_state = smpwm_pkg::ST_EMIT;
                end else if (i_sts.latch) begin
                    n_state = smpwm_pkg::ST_LOAD;
                end else begin
                    n_state = smpwm_pkg::ST_START;
                end
            end
            smpwm_pkg::ST_LOAD: begin
                o_cmd.load = 1'b1;
                n_state    = smpwm_pkg::ST_CMP;
            end
            smpwm_pkg::ST_CMP: begin
                o_cmd.cmp = 1'b1;
                if (i_sts.j_last) begin
                    n_state = i_sts.i_last ? smpwm_pkg::ST_START : smpwm_pkg::ST_LOAD;
                end
            end
            smpwm_pkg::ST_START: begin
                o_cmd.start = 1'b1;
                n_state     = smpwm_pkg::ST_PINS;
            end
            smpwm_pkg::ST_PINS: begin
                o_cmd.pins = 1'b1;
                n_state    = smpwm_pkg::ST_EMIT;
            end
            smpwm_pkg::ST_EMIT: begin
                if (i_sts.out_free) begin
                    o_cmd.emit = 1'b1;
                    n_state    = smpwm_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = smpwm_pkg::ST_IDLE;
            end
        endcase
    end

    assign o_busy = (r_state != smpwm_pkg::ST_IDLE);

endmodule

`default_nettype wire

>>> rtl/core/smpwm_dp.sv
// ----------------------------------------------------------------------------
// smpwm_dp
// Datapath: pending and active settings, phase counter, rank exchange
// registers, per-rank start offsets, pin compare lanes and output register.
// ----------------------------------------------------------------------------
`default_nettype none

module smpwm_dp #(
    parameter int unsigned CHANNELS = 8
) (
    input  wire logic                                  i_clk,
    input  wire logic                                  i_rst_n,
    input  smpwm_pkg::t_cmd                            i_cmd,
    output smpwm_pkg::t_sts                            o_sts,
    input  smpwm_pkg::t_in_item                        i_in_item,
    input  wire logic [smpwm_pkg::PERIOD_W-1:0]        i_period,
    input  wire logic [smpwm_pkg::STAGGER_W-1:0]       i_stagger,
    output logic                                       o_out_valid,
    input  wire logic                                  i_out_stall,
    output smpwm_pkg::t_out_item                       o_out_item
);

    localparam int unsigned CH_W    = $clog2(CHANNELS);
    localparam int unsigned START_W = smpwm_pkg::STAGGER_W + CH_W;
    localparam int unsigned CMP_W   =
        ((START_W > smpwm_pkg::VALUE_W) ? START_W : smpwm_pkg::VALUE_W) + 1;
    localparam int unsigned CHX_W   =
        ((CH_W > smpwm_pkg::PIN_IDX_W) ? CH_W : smpwm_pkg::PIN_IDX_W) + 1;

    smpwm_pkg::t_in_item                 r_item;
    logic [smpwm_pkg::PERIOD_W-1:0]      r_phase;
    logic [smpwm_pkg::VALUE_W-1:0]       r_pend_w [CHANNELS];
    logic [smpwm_pkg::PIN_W-1:0]         r_pend_en;
    logic [smpwm_pkg::PIN_W-1:0]         r_en;
    logic [smpwm_pkg::VALUE_W-1:0]       r_w [CHANNELS];
    logic [CH_W-1:0]                     r_rank [CHANNELS];
    logic [smpwm_pkg::VALUE_W-1:0]       r_cur_w;
    logic [CH_W-1:0]                     r_cur_r;
    logic [CH_W-1:0]                     r_i;
    logic [CH_W-1:0]                     r_j;
    logic [START_W-1:0]                  r_start [CHANNELS];
    logic [smpwm_pkg::PIN_W-1:0]         r_pins;
    logic                                r_flag;
    logic                                r_out_valid;
    smpwm_pkg::t_out_item                r_out_item;

    logic [smpwm_pkg::PERIOD_W-1:0]      period_eff;
    logic [smpwm_pkg::PERIOD_W-1:0]      phase_eff;
    logic [smpwm_pkg::PERIOD_W:0]        phase_inc;
    logic                                phase_wrap;
    logic [CH_W-1:0]                     rd_idx;
    logic [smpwm_pkg::VALUE_W-1:0]       rd_w;
    logic [CH_W-1:0]                     rd_rank;
    logic                                swap;
    logic [smpwm_pkg::VALUE_W-1:0]       n_cur_w;
    logic [CH_W-1:0]                     n_cur_r;
    logic                                wr_ok;
    logic [smpwm_pkg::PIN_W-1:0]         pins_v;
    logic                                out_free;

    // Phase bookkeeping; a zero period acts as one
    assign period_eff = (i_period == '0) ? smpwm_pkg::PERIOD_W'(1) : i_period;
    assign phase_eff  = (r_phase >= period_eff) ? '0 : r_phase;
    assign phase_inc  = {1'b0, r_phase} + (smpwm_pkg::PERIOD_W + 1)'(1);
    assign phase_wrap = (phase_inc >= {1'b0, period_eff});

    // One exchange read port: slot i when loading a pass, slot j otherwise
    assign rd_idx  = i_cmd.load ? r_i : r_j;
    assign rd_w    = r_w[rd_idx];
    assign rd_rank = r_rank[rd_idx];
    assign swap    = (rd_w < r_cur_w);
    assign n_cur_w = swap ? rd_w : r_cur_w;
    assign n_cur_r = swap ? rd_rank : r_cur_r;

    // Ignore width writes to channels the block does not have
    assign wr_ok = (32'(r_item.channel) < 32'(CHANNELS));

    // Pin lanes, one per rank
    always_comb begin
        logic [CHX_W-1:0] ch_x;
        logic [CMP_W-1:0] stop;
        pins_v = '0;
        for (int r = 0; r < CHANNELS; r++) begin
            ch_x = CHX_W'(r_rank[r]);
            stop = CMP_W'(r_start[r]) + CMP_W'(r_w[r]);
            if ((ch_x < CHX_W'(smpwm_pkg::PIN_W)) &&
                r_en[ch_x[smpwm_pkg::PIN_IDX_W-1:0]] &&
                (CMP_W'(r_start[r]) <= CMP_W'(r_phase)) &&
                (CMP_W'(r_phase) < stop)) begin
                pins_v[ch_x[smpwm_pkg::PIN_IDX_W-1:0]] = 1'b1;
            end
        end
    end

    assign out_free = !r_out_valid || !i_out_stall;

    // Status to the controller
    always_comb begin
        o_sts          = '0;
        o_sts.is_tick  = (r_item.func == smpwm_pkg::FUNC_TICK);
        o_sts.latch    = (phase_eff == '0);
        o_sts.j_last   = (r_j == CH_W'(CHANNELS - 1));
        o_sts.i_last   = (r_i == CH_W'(CHANNELS - 2));
        o_sts.out_free = out_free;
    end

    // Control and settings state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= '0;
            r_pend_en   <= smpwm_pkg::ENABLE_ALL;
            r_en        <= '0;
            r_cur_w     <= '0;
            r_cur_r     <= '0;
            r_i         <= '0;
            r_j         <= '0;
            r_pins      <= '0;
            r_out_valid <= 1'b0;
            for (int c = 0; c < CHANNELS; c++) begin
                r_pend_w[c] <= smpwm_pkg::RESET_WIDTH;
                r_w[c]      <= smpwm_pkg::RESET_WIDTH;
                r_rank[c]   <= CH_W'(c);
            end
        end else begin
            // Apply a write, or settle the phase and latch on a period start
            if (i_cmd.decode) begin
                if (r_item.func == smpwm_pkg::FUNC_TICK) begin
                    r_phase <= phase_eff;
                    if (phase_eff == '0) begin
                        r_en <= r_pend_en;
                        r_i  <= '0;
                        for (int c = 0; c < CHANNELS; c++) begin
                            r_w[c]    <= r_pend_w[c];
                            r_rank[c] <= CH_W'(c);
                        end
                    end
                end else begin
                    case (r_item.func)
                        smpwm_pkg::FUNC_WIDTH: begin
                            if (wr_ok) begin
                                r_pend_w[CH_W'(r_item.channel)] <= r_item.value;
                            end
                        end
                        smpwm_pkg::FUNC_MASK: begin
                            r_pend_en <= r_item.value[smpwm_pkg::PIN_W-1:0];
                        end
                        default: begin
                        end
                    endcase
                end
            end

            // Open an exchange pass at slot i
            if (i_cmd.load) begin
                r_cur_w <= rd_w;
                r_cur_r <= rd_rank;
                r_j     <= CH_W'(r_i + 1'b1);
            end

            // Compare slot j with the running minimum, swap when smaller
            if (i_cmd.cmp) begin
                if (swap) begin
                    r_w[r_j]    <= r_cur_w;
                    r_rank[r_j] <= r_cur_r;
                end
                r_cur_w <= n_cur_w;
                r_cur_r <= n_cur_r;
                r_j     <= CH_W'(r_j + 1'b1);
                if (r_j == CH_W'(CHANNELS - 1)) begin
                    r_w[r_i]    <= n_cur_w;
                    r_rank[r_i] <= n_cur_r;
                    r_i         <= CH_W'(r_i + 1'b1);
                end
            end

            // Register the pin vector and advance the phase
            if (i_cmd.pins) begin
                r_pins  <= pins_v;
                r_phase <= phase_wrap ? '0 : phase_inc[smpwm_pkg::PERIOD_W-1:0];
            end

            // Output register
            if (i_cmd.emit) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_item <= i_in_item;
        end
        if (i_cmd.decode) begin
            r_flag <= (r_item.func == smpwm_pkg::FUNC_TICK) && (phase_eff == '0);
        end
        // Start offset of each rank
        if (i_cmd.start) begin
            for (int r = 0; r < CHANNELS; r++) begin
                r_start[r] <= START_W'(START_W'(r) * START_W'(i_stagger));
            end
        end
        if (i_cmd.emit) begin
            r_out_item.pins         <= r_pins;
            r_out_item.period_start <= r_flag;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

`ifndef SYNTH
    logic                w_ordered;
    logic [CHANNELS-1:0] rank_cover;

    always_comb begin
        w_ordered  = 1'b1;
        rank_cover = '0;
        for (int r = 0; r < CHANNELS; r++) begin
            rank_cover[r_rank[r]] = 1'b1;
        end
        for (int r = 0; r < CHANNELS - 1; r++) begin
            if (r_w[r + 1] < r_w[r]) begin
                w_ordered = 1'b0;
            end
        end
    end

    // Widths are in ascending order whenever pins are about to be evaluated
    a_sorted: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.start |-> w_ordered)
        else $error("rank widths not ascending");

    // Ranks form a permutation of the channels whenever pins are about to be evaluated
    a_perm: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.start |-> (rank_cover == {CHANNELS{1'b1}}))
        else $error("rank table is not a permutation");

    // Phase stays inside the period it was advanced against
    a_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.pins |=> (r_phase < $past(period_eff)))
        else $error("phase past period end");

    // A result is loaded only into a free output register
    a_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.emit |-> out_free)
        else $error("result overwrote a waiting result");
`endif

endmodule

`default_nettype wire

>>> rtl/core/staggered_multichannel_pwm.sv
// ----------------------------------------------------------------------------
// staggered_multichannel_pwm
// Multichannel servo PWM with rank-staggered pulse starts.
//
//   channel  direction  handshake              payload
//   in       sink       i_in_valid/o_in_stall  i_in_item  (func, channel, value)
//   out      source     o_out_valid/i_out_stall o_out_item (pins, period_start)
//   cfg      sink       i_cfg_valid/o_cfg_ready i_cfg_index, i_cfg_data
//
// A write item is decoded, then loaded as a result; a tick is decoded, sets
// start offsets and registers its pins first. A tick at phase 0 also runs the
// rank exchange, one compare per cycle on a single compare unit.
// One item is in work at a time; a result waiting in the output register
// does not block the next accept, only the next result load.
// Reset is synchronous; it clears settings to their defaults and the pins.
// Items are held off and configuration writes are not ready during reset.
// ----------------------------------------------------------------------------
`default_nettype none

module staggered_multichannel_pwm #(
    parameter int unsigned CHANNELS = 8
) (
    input  wire logic                                   i_clk,
    input  wire logic                                   i_rst_n,
    input  wire logic                                   i_in_valid,
    output logic                                        o_in_stall,
    input  smpwm_pkg::t_in_item                         i_in_item,
    output logic                                        o_out_valid,
    input  wire logic                                   i_out_stall,
    output smpwm_pkg::t_out_item                        o_out_item,
    input  wire logic                                   i_cfg_valid,
    output logic                                        o_cfg_ready,
    input  wire logic [smpwm_pkg::CFG_IDX_W-1:0]        i_cfg_index,
    input  wire logic [smpwm_pkg::PERIOD_W-1:0]         i_cfg_data
);

    logic [smpwm_pkg::PERIOD_W-1:0]  r_period;
    logic [smpwm_pkg::STAGGER_W-1:0] r_stagger;
    smpwm_pkg::t_cmd                 cmd;
    smpwm_pkg::t_sts                 sts;
    logic                            busy;

    assign o_cfg_ready = i_rst_n;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_period  <= smpwm_pkg::RESET_PERIOD;
            r_stagger <= smpwm_pkg::RESET_STAGGER;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                smpwm_pkg::CFG_PERIOD: begin
                    r_period <= i_cfg_data;
                end
                smpwm_pkg::CFG_STAGGER: begin
                    r_stagger <= i_cfg_data[smpwm_pkg::STAGGER_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    // Hold off new items while one is in work or reset is asserted
    assign o_in_stall = busy || !i_rst_n;

    smpwm_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_sts      (sts),
        .o_busy     (busy),
        .o_cmd      (cmd)
    );

    smpwm_dp #(
        .CHANNELS (CHANNELS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .i_in_item   (i_in_item),
        .i_period    (r_period),
        .i_stagger   (r_stagger),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_item  (o_out_item)
    );

endmodule

`default_nettype wire

>>> sim/smpwm_checker.sv
// ----------------------------------------------------------------------------
// smpwm_checker
// Watches the item, result and register channels of the staggered PWM block,
// predicts every pin vector from its own copy of the block state, and
// compares each result against the oldest prediction.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module smpwm_checker (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             i_in_valid,
    input  wire logic                             i_in_stall,
    input  smpwm_pkg::t_in_item                   i_in_item,
    input  wire logic                             i_out_valid,
    input  wire logic                             i_out_stall,
    input  smpwm_pkg::t_out_item                  i_out_item,
    input  wire logic                             i_cfg_valid,
    input  wire logic                             i_cfg_ready,
    input  wire logic [smpwm_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [smpwm_pkg::PERIOD_W-1:0]   i_cfg_data,
    output int                                    o_errors,
    output int                                    o_pending
);

    localparam int NCH        = 8;
    localparam int REPORT_MAX = 10;

    // Mirror of the block's settings and state
    logic [smpwm_pkg::PERIOD_W-1:0]  period_cfg;
    logic [smpwm_pkg::STAGGER_W-1:0] stagger_cfg;
    logic [31:0]                     phase;
    logic [smpwm_pkg::VALUE_W-1:0]   pend_width [NCH];
    logic [smpwm_pkg::VALUE_W-1:0]   act_width  [NCH];
    logic [2:0]                      rank_chan  [NCH];
    logic [smpwm_pkg::PIN_W-1:0]     pend_enable;
    logic [smpwm_pkg::PIN_W-1:0]     act_enable;
    logic [smpwm_pkg::PIN_W-1:0]     last_pins;

    smpwm_pkg::t_out_item expected_pins_q [$];
    int                   errors = 0;

    // Rank channels by ascending width with the selection exchange order
    function automatic void rank_by_width();
        logic [smpwm_pkg::VALUE_W-1:0] w [NCH];
        logic [smpwm_pkg::VALUE_W-1:0] tw;
        logic [2:0]                    tr;
        int                            i;
        int                            j;
        for (i = 0; i < NCH; i++) begin
            w[i]         = act_width[i];
            rank_chan[i] = 3'(i);
        end
        for (i = 0; i < NCH; i++) begin
            for (j = i; j < NCH; j++) begin
                if (w[j] < w[i]) begin
                    tw           = w[i];
                    w[i]         = w[j];
                    w[j]         = tw;
                    tr           = rank_chan[i];
                    rank_chan[i] = rank_chan[j];
                    rank_chan[j] = tr;
                end
            end
        end
    endfunction

    // Pin vector at a given phase; start and stop are held at 64 bits
    function automatic logic [smpwm_pkg::PIN_W-1:0] pins_at_phase(input logic [31:0] ph);
        logic [63:0]                 lo;
        logic [63:0]                 hi;
        logic [2:0]                  ch;
        logic [smpwm_pkg::PIN_W-1:0] v;
        int                          r;
        v = '0;
        for (r = 0; r < NCH; r++) begin
            ch = rank_chan[r];
            if (act_enable[ch]) begin
                lo = 64'(r) * 64'(stagger_cfg);
                hi = lo + 64'(act_width[ch]);
                if (lo <= 64'(ph) && 64'(ph) < hi)
                    v[ch] = 1'b1;
            end
        end
        return v;
    endfunction

    // Advance the mirror by one item and return the pin vector it causes
    function automatic smpwm_pkg::t_out_item step_pwm(input smpwm_pkg::t_in_item it);
        logic [smpwm_pkg::PERIOD_W-1:0] per;
        smpwm_pkg::t_out_item           res;
        int                             c;
        per              = (period_cfg == '0) ? 32'd1 : period_cfg;
        res.period_start = 1'b0;
        case (it.func)
            smpwm_pkg::FUNC_WIDTH: begin
                pend_width[it.channel] = it.value;
            end
            smpwm_pkg::FUNC_MASK: begin
                pend_enable = it.value[smpwm_pkg::PIN_W-1:0];
            end
            smpwm_pkg::FUNC_TICK: begin
                if (phase >= per)
                    phase = '0;
                // Latch the pending set at the start of a period
                if (phase == '0) begin
                    for (c = 0; c < NCH; c++)
                        act_width[c] = pend_width[c];
                    act_enable = pend_enable;
                    rank_by_width();
                    res.period_start = 1'b1;
                end
                last_pins = pins_at_phase(phase);
                phase     = phase + 32'd1;
                if (phase >= per)
                    phase = '0;
            end
            default: ;
        endcase
        res.pins = last_pins;
        return res;
    endfunction

    // Sample all channels at the rising edge
    always @(posedge i_clk) begin
        smpwm_pkg::t_out_item want;
        int                   c;
        if (!i_rst_n) begin
            period_cfg  = smpwm_pkg::RESET_PERIOD;
            stagger_cfg = smpwm_pkg::RESET_STAGGER;
            phase       = '0;
            for (c = 0; c < NCH; c++) begin
                pend_width[c] = smpwm_pkg::RESET_WIDTH;
                act_width[c]  = smpwm_pkg::RESET_WIDTH;
                rank_chan[c]  = 3'(c);
            end
            pend_enable = smpwm_pkg::ENABLE_ALL;
            act_enable  = '0;
            last_pins   = '0;
            expected_pins_q.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    smpwm_pkg::CFG_PERIOD:  period_cfg  = i_cfg_data;
                    smpwm_pkg::CFG_STAGGER: stagger_cfg = i_cfg_data[smpwm_pkg::STAGGER_W-1:0];
                    default: ;
                endcase
            end
            // Compare the delivered result with the oldest prediction
            if (i_out_valid && !i_out_stall) begin
                if (expected_pins_q.size() == 0) begin
                    errors++;
                    if (errors <= REPORT_MAX)
                        $display("%0t: unexpected result pins=%h start=%b", $realtime,
                                 i_out_item.pins, i_out_item.period_start);
                end else begin
                    want = expected_pins_q.pop_front();
                    if (want.pins !== i_out_item.pins ||
                        want.period_start !== i_out_item.period_start) begin
                        errors++;
                        if (errors <= REPORT_MAX)
                            $display("%0t: mismatch pins exp=%h got=%h start exp=%b got=%b",
                                     $realtime, want.pins, i_out_item.pins,
                                     want.period_start, i_out_item.period_start);
                    end
                end
            end
            if (i_in_valid && !i_in_stall)
                expected_pins_q.push_back(step_pwm(i_in_item));
        end
        o_errors  <= errors;
        o_pending <= expected_pins_q.size();
    end

endmodule

>>> sim/tb.sv
// ----------------------------------------------------------------------------
// tb
// Drives the staggered PWM block with timer ticks, width writes and mask
// writes under several period and stagger settings, with random idling on
// both channels and one long output hold-off; the checker beside the block
// predicts and compares every pin vector.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb;

    localparam int         NUM_SWEEPS    = 8;
    localparam int         SWEEP_ITEMS   = 88;
    localparam int         QUIET_LIMIT   = 2000;
    localparam int         HOLD_CYCLES   = 120;
    localparam int         HOLD_AFTER    = 260;
    localparam int         SETTLE_CYCLES = 4;
    localparam int         DRAIN_CYCLES  = 64;
    localparam logic [1:0] FUNC_UNUSED   = 2'd3;

    typedef enum int {
        PACE_SLOW_SINK,
        PACE_SLOW_SOURCE,
        PACE_FULL
    } t_pace;

    logic                            clk        = 1'b0;
    logic                            rst_n      = 1'b0;
    logic                            in_valid   = 1'b0;
    smpwm_pkg::t_in_item             in_item    = '0;
    logic                            out_stall  = 1'b0;
    logic                            cfg_valid  = 1'b0;
    logic [smpwm_pkg::CFG_IDX_W-1:0] cfg_index  = '0;
    logic [smpwm_pkg::PERIOD_W-1:0]  cfg_data   = '0;
    logic                            in_stall;
    logic                            out_valid;
    smpwm_pkg::t_out_item            out_item;
    logic                            cfg_ready;
    int                              errors;
    int                              pending;
    t_pace                           pace        = PACE_FULL;
    int                              sent_count  = 0;
    int                              quiet_count = 0;
    bit                              hold_done   = 1'b0;

    logic [smpwm_pkg::PERIOD_W-1:0]  sweep_period  [NUM_SWEEPS] =
        '{32'd40, 32'hFFFF_FFFF, 32'd24, 32'd1, 32'd60, 32'd13, 32'd90, 32'd31};
    logic [smpwm_pkg::STAGGER_W-1:0] sweep_stagger [NUM_SWEEPS] =
        '{16'd3, 16'hFFFF, 16'd2, 16'd0, 16'd7, 16'd1, 16'd11, 16'd4};

    always #2 clk = ~clk;

    staggered_multichannel_pwm #(
        .CHANNELS (8)
    ) i_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_item   (in_item),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_item  (out_item),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    smpwm_checker u_check (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .i_in_stall  (in_stall),
        .i_in_item   (in_item),
        .i_out_valid (out_valid),
        .i_out_stall (out_stall),
        .i_out_item  (out_item),
        .i_cfg_valid (cfg_valid),
        .i_cfg_ready (cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data),
        .o_errors    (errors),
        .o_pending   (pending)
    );

    function automatic smpwm_pkg::t_in_item make_item(
        input smpwm_pkg::t_func                 f,
        input logic [smpwm_pkg::CHAN_W-1:0]     ch,
        input logic [smpwm_pkg::VALUE_W-1:0]    v);
        smpwm_pkg::t_in_item it;
        it.func    = f;
        it.channel = ch;
        it.value   = v;
        return it;
    endfunction

    // Mostly ticks and small widths so pulses land inside short periods
    function automatic smpwm_pkg::t_in_item random_item(
        input logic [smpwm_pkg::PERIOD_W-1:0] per);
        smpwm_pkg::t_in_item it;
        int unsigned         roll;
        int unsigned         span;
        roll       = $urandom_range(0, 99);
        span       = (per == '0 || per > 32'd1000) ? 1000 : int'(per);
        it.channel = smpwm_pkg::CHAN_W'($urandom_range(0, 7));
        it.value   = $urandom;
        if (roll < 60) begin
            it.func = smpwm_pkg::FUNC_TICK;
        end else if (roll < 85) begin
            it.func = smpwm_pkg::FUNC_WIDTH;
            case ($urandom_range(0, 9))
                0: ;
                1, 2: it.value = $urandom_range(0, 3) * (span / 4);
                default: it.value = $urandom_range(0, span + 8);
            endcase
        end else if (roll < 98) begin
            it.func = smpwm_pkg::FUNC_MASK;
            if ($urandom_range(0, 2) != 0)
                it.value = $urandom_range(0, 255);
        end else begin
            it.func = smpwm_pkg::t_func'(FUNC_UNUSED);
        end
        return it;
    endfunction

    function automatic bit roll_pct(input int pct);
        return $urandom_range(0, 99) < pct;
    endfunction

    // Offer one item, with random gaps ahead of it; entered at a falling edge
    task automatic offer(input smpwm_pkg::t_in_item it);
        while (roll_pct(pace == PACE_SLOW_SINK ? 16 : pace == PACE_SLOW_SOURCE ? 50 : 0)) begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        in_item  <= it;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        sent_count++;
        @(negedge clk);
    endtask

    task automatic write_reg(input logic [smpwm_pkg::CFG_IDX_W-1:0] idx,
                             input logic [smpwm_pkg::PERIOD_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        @(negedge clk);
    endtask

    // Drain all results, then rewrite both registers while the block is idle
    task automatic reconfigure(input logic [smpwm_pkg::PERIOD_W-1:0] per,
                               input logic [smpwm_pkg::STAGGER_W-1:0] stg);
        in_valid <= 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
        write_reg(smpwm_pkg::CFG_PERIOD, per);
        write_reg(smpwm_pkg::CFG_STAGGER, 32'(stg));
        cfg_valid <= 1'b0;
    endtask

    // Result side: one long hold-off, otherwise random stalls per pace
    initial begin
        forever begin
            @(negedge clk);
            if (!hold_done && sent_count >= HOLD_AFTER) begin
                hold_done = 1'b1;
                out_stall <= 1'b1;
                repeat (HOLD_CYCLES - 1) @(negedge clk);
            end else begin
                out_stall <= roll_pct(pace == PACE_SLOW_SINK   ? 50 :
                                      pace == PACE_SLOW_SOURCE ? 16 : 0);
            end
        end
    end

    // Abort when no channel moves for too long
    always @(posedge clk) begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready)) begin
            quiet_count <= 0;
        end else if (quiet_count + 1 >= QUIET_LIMIT) begin
            $display("tb: failure");
            $finish;
        end else begin
            quiet_count <= quiet_count + 1;
        end
    end

    initial begin
        int s;
        repeat (2) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Reset settings: width extremes, mask with only high bits, unused code
        offer(make_item(smpwm_pkg::FUNC_TICK, 3'd0, 32'd0));
        offer(make_item(smpwm_pkg::FUNC_WIDTH, 3'd0, 32'd0));
        offer(make_item(smpwm_pkg::FUNC_WIDTH, 3'd7, 32'hFFFF_FFFF));
        offer(make_item(smpwm_pkg::FUNC_WIDTH, 3'd3, 32'h8000_0000));
        offer(make_item(smpwm_pkg::FUNC_MASK, 3'd5, 32'hFFFF_FF00));
        offer(make_item(smpwm_pkg::t_func'(FUNC_UNUSED), 3'd7, 32'hFFFF_FFFF));
        offer(make_item(smpwm_pkg::FUNC_TICK, 3'd7, 32'hFFFF_FFFF));

        // Shorten the period below the running phase
        reconfigure(32'd1, 16'd1);
        offer(make_item(smpwm_pkg::FUNC_TICK, 3'd0, 32'd0));
        offer(make_item(smpwm_pkg::FUNC_MASK, 3'd0, 32'h0000_00A5));
        offer(make_item(smpwm_pkg::FUNC_WIDTH, 3'd1, 32'd1));
        offer(make_item(smpwm_pkg::FUNC_TICK, 3'd0, 32'd0));

        // Zero period with the widest stagger
        reconfigure(32'd0, 16'hFFFF);
        offer(make_item(smpwm_pkg::FUNC_TICK, 3'd0, 32'd0));
        offer(make_item(smpwm_pkg::FUNC_TICK, 3'd0, 32'd0));

        // No stagger, tied widths, all channels on
        reconfigure(32'd6, 16'd0);
        offer(make_item(smpwm_pkg::FUNC_WIDTH, 3'd2, 32'd5));
        offer(make_item(smpwm_pkg::FUNC_WIDTH, 3'd5, 32'd5));
        offer(make_item(smpwm_pkg::FUNC_MASK, 3'd0, 32'h0000_00FF));
        repeat (8) offer(make_item(smpwm_pkg::FUNC_TICK, 3'd0, 32'd0));

        // Random sweeps over several settings and pacing modes
        for (s = 0; s < NUM_SWEEPS; s++) begin
            reconfigure(sweep_period[s], sweep_stagger[s]);
            pace = (s < 3) ? PACE_SLOW_SINK : (s < 6) ? PACE_SLOW_SOURCE : PACE_FULL;
            repeat (SWEEP_ITEMS) offer(random_item(sweep_period[s]));
        end

        in_valid <= 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
        if (errors == 0 && pending == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

>>> files.f
rtl/core/smpwm_pkg.sv
rtl/core/smpwm_ctrl.sv
rtl/core/smpwm_dp.sv
rtl/core/staggered_multichannel_pwm.sv
sim/smpwm_checker.sv
sim/tb.sv
